>>> design/vsb_pkg.sv
// Shared constants, types and controller/datapath interface of the voxel sphere brush.
`default_nettype none
package vsb_pkg;

	localparam int MAX_DIM = 64;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int HALF_W = IDX_W + 1;
	localparam int ROW_AW = 2 * IDX_W;
	localparam int ROWS = 2 ** ROW_AW;

	localparam int CTR_W = 6;
	localparam int SIZE_W = 7;
	localparam int PITCH_W = 16;
	localparam int RAD_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int M_W = IDX_W + PITCH_W;
	localparam int SQ_W = 2 * M_W;
	localparam int R2_W = 2 * RAD_W;
	localparam int DIST_W = SQ_W + 2;

	localparam int DIV_NUM_W = RAD_W + 1;
	localparam int DIV_DEN_W = PITCH_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd6;

	localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;
	localparam logic [PITCH_W-1:0] PITCH_RST = 16'd256;
	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd768;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		SQ_NONE,
		SQ_Z,
		SQ_Y,
		SQ_X
	} sq_kind_t;

	typedef struct packed {
		logic accept;
		logic clr_we;
		logic div_start;
		logic span_load;
		axis_t axis;
		logic init_k;
		logic inc_k;
		logic init_j;
		logic inc_j;
		logic init_i;
		logic inc_i;
		sq_kind_t sq;
		logic row_rd;
		logic row_wr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic in_vol;
		logic div_done;
		logic i_last;
		logic j_last;
		logic k_last;
		logic clr_last;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> design/voxel_sphere_brush_paint.sv
// Top level of the voxel sphere brush painter.
// Usage:
//  - Input channel (in_valid/in_ready) takes one item: action 0 paints a sphere of
//    brush_radius around (center_i, center_j, center_k), action 1 reads one mask bit.
//  - Output channel (out_valid/out_ready) gives exactly one result per item:
//    changed for paints, mask_bit for reads.
//  - Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken;
//    issue them only while no item is in progress.
//  - After reset the mask memory is cleared one row per cycle, all 2**(2*log2(MAX_DIM))
//    rows (4096 at MAX_DIM 64); in_ready stays low until that pass is done.
//  - One item is worked at a time. A read steps through dispatch, row read and read wait.
//  - A paint runs three serial divisions for the box half-widths, then walks the clipped
//    box: per plane a z-offset step, per row a row read, the x run over its voxels,
//    drain states and a write-back, set by the single distance pipeline and the
//    one-row mask port. A centre outside the volume goes from dispatch to the result.
//  - A finished result waits in an output register; the next item is accepted while
//    it waits, and the block stalls at its end only if that register is still full.
`default_nettype none
module voxel_sphere_brush_paint (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [vsb_pkg::CTR_W-1:0]       center_i,
	input  logic [vsb_pkg::CTR_W-1:0]       center_j,
	input  logic [vsb_pkg::CTR_W-1:0]       center_k,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            changed,
	output logic                            mask_bit,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import vsb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	vsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vsb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.center_i  (center_i),
		.center_j  (center_j),
		.center_k  (center_k),
		.cmd       (cmd),
		.stat      (stat),
		.changed   (changed),
		.mask_bit  (mask_bit)
	);

endmodule
`default_nettype wire

>>> design/vsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/vsb_div.sv
// Restoring divider, one quotient bit per cycle, for the brush half-width.
`default_nettype none
module vsb_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [vsb_pkg::DIV_NUM_W-1:0]  num,
	input  logic [vsb_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [vsb_pkg::DIV_NUM_W-1:0]  quo
);
	import vsb_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule
`default_nettype wire

>>> design/vsb_dp.sv
// Datapath: configuration registers, box spans, distance pipeline and mask memory.
`default_nettype none
module vsb_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [vsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vsb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            action,
	input  logic [vsb_pkg::CTR_W-1:0]       center_i,
	input  logic [vsb_pkg::CTR_W-1:0]       center_j,
	input  logic [vsb_pkg::CTR_W-1:0]       center_k,
	input  vsb_pkg::dp_cmd_t                cmd,
	output vsb_pkg::dp_stat_t               stat,
	output logic                            changed,
	output logic                            mask_bit
);
	import vsb_pkg::*;

	function automatic logic [IDX_W-1:0] eff_last(input logic [SIZE_W-1:0] s);
		logic [IDX_W-1:0] r;
		if (s == '0) begin
			r = '0;
		end else if (int'(s) > MAX_DIM) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(s - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [PITCH_W-1:0] eff_pitch(input logic [PITCH_W-1:0] p);
		return (p == '0) ? PITCH_W'(1) : p;
	endfunction

	// configuration registers
	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [PITCH_W-1:0] pitch_x_q, pitch_y_q, pitch_z_q;
	logic [RAD_W-1:0]   radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RST;
			size_y_q <= SIZE_RST;
			size_z_q <= SIZE_RST;
			pitch_x_q <= PITCH_RST;
			pitch_y_q <= PITCH_RST;
			pitch_z_q <= PITCH_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= cfg_data[SIZE_W-1:0];
				REG_PITCH_X: pitch_x_q <= cfg_data[PITCH_W-1:0];
				REG_PITCH_Y: pitch_y_q <= cfg_data[PITCH_W-1:0];
				REG_PITCH_Z: pitch_z_q <= cfg_data[PITCH_W-1:0];
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// item captured at accept
	logic               act_q, inside_q;
	logic [IDX_W-1:0]   ci_q, cj_q, ck_q;
	logic [IDX_W-1:0]   nm1_x_q, nm1_y_q, nm1_z_q;
	logic [PITCH_W-1:0] px_q, py_q, pz_q;
	logic [RAD_W-1:0]   r_q;
	logic [R2_W-1:0]    r2_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= action;
			inside_q <= (int'(center_i) <= int'(eff_last(size_x_q)))
				&& (int'(center_j) <= int'(eff_last(size_y_q)))
				&& (int'(center_k) <= int'(eff_last(size_z_q)));
			ci_q <= IDX_W'(center_i);
			cj_q <= IDX_W'(center_j);
			ck_q <= IDX_W'(center_k);
			nm1_x_q <= eff_last(size_x_q);
			nm1_y_q <= eff_last(size_y_q);
			nm1_z_q <= eff_last(size_z_q);
			px_q <= eff_pitch(pitch_x_q);
			py_q <= eff_pitch(pitch_y_q);
			pz_q <= eff_pitch(pitch_z_q);
			r_q <= radius_q;
		end
		r2_q <= R2_W'(r_q) * R2_W'(r_q);
	end

	// half-width division and span clipping
	logic [PITCH_W-1:0]   p_sel;
	logic [IDX_W-1:0]     c_sel, nm1_sel;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic                 div_done;
	logic [HALF_W-1:0]    half;
	logic [IDX_W+1:0]     hi_sum;
	logic [IDX_W-1:0]     lo_new, hi_new;

	always_comb begin
		unique case (cmd.axis)
			AXIS_X: begin
				p_sel = px_q;
				c_sel = ci_q;
				nm1_sel = nm1_x_q;
			end
			AXIS_Y: begin
				p_sel = py_q;
				c_sel = cj_q;
				nm1_sel = nm1_y_q;
			end
			AXIS_Z: begin
				p_sel = pz_q;
				c_sel = ck_q;
				nm1_sel = nm1_z_q;
			end
			default: begin
				p_sel = px_q;
				c_sel = ci_q;
				nm1_sel = nm1_x_q;
			end
		endcase
	end

	assign div_num = DIV_NUM_W'(r_q) + DIV_NUM_W'(p_sel) - DIV_NUM_W'(1);

	vsb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (p_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		half = (div_quo > DIV_NUM_W'(MAX_DIM)) ? HALF_W'(MAX_DIM) : HALF_W'(div_quo);
		lo_new = ({1'b0, c_sel} <= half) ? '0 : IDX_W'({1'b0, c_sel} - half);
		hi_sum = {2'b00, c_sel} + {1'b0, half};
		hi_new = (hi_sum > (IDX_W + 2)'(nm1_sel)) ? nm1_sel : IDX_W'(hi_sum);
	end

	logic [IDX_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;

	always_ff @(posedge clk) begin
		if (cmd.span_load && div_done) begin
			unique case (cmd.axis)
				AXIS_X: begin
					lo_x_q <= lo_new;
					hi_x_q <= hi_new;
				end
				AXIS_Y: begin
					lo_y_q <= lo_new;
					hi_y_q <= hi_new;
				end
				AXIS_Z: begin
					lo_z_q <= lo_new;
					hi_z_q <= hi_new;
				end
				default: ;
			endcase
		end
	end

	// box walk counters
	logic [IDX_W-1:0] i_q, j_q, k_q;

	always_ff @(posedge clk) begin
		if (cmd.init_i) begin
			i_q <= lo_x_q;
		end else if (cmd.inc_i) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.init_j) begin
			j_q <= lo_y_q;
		end else if (cmd.inc_j) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.init_k) begin
			k_q <= lo_z_q;
		end else if (cmd.inc_k) begin
			k_q <= k_q + 1'b1;
		end
	end

	// squared offset pipeline: |a-c|*p, then square, then accumulate/compare
	logic [IDX_W-1:0]   sq_a, sq_c, sq_d;
	logic [PITCH_W-1:0] sq_p;
	sq_kind_t           kind_s1, kind_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [M_W-1:0]     m_s1;
	logic [SQ_W-1:0]    sq_s2;
	logic [SQ_W-1:0]    dz2_q;
	logic [SQ_W:0]      dyz2_q;
	logic [DIST_W-1:0]  dist_sum;
	logic               hit;

	always_comb begin
		unique case (cmd.sq)
			SQ_Z: begin
				sq_a = k_q;
				sq_c = ck_q;
				sq_p = pz_q;
			end
			SQ_Y: begin
				sq_a = j_q;
				sq_c = cj_q;
				sq_p = py_q;
			end
			SQ_X, SQ_NONE: begin
				sq_a = i_q;
				sq_c = ci_q;
				sq_p = px_q;
			end
		endcase
		sq_d = (sq_a >= sq_c) ? sq_a - sq_c : sq_c - sq_a;
	end

	assign dist_sum = DIST_W'(dyz2_q) + DIST_W'(sq_s2);
	assign hit = dist_sum <= DIST_W'(r2_q);

	logic [MAX_DIM-1:0] row_q, ram_rdata;
	logic               rd_pend_q, changed_q;
	logic [ROW_AW-1:0]  clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= SQ_NONE;
			kind_s2 <= SQ_NONE;
			rd_pend_q <= 1'b0;
			changed_q <= 1'b0;
			clr_q <= '0;
		end else begin
			kind_s1 <= cmd.sq;
			kind_s2 <= kind_s1;
			rd_pend_q <= cmd.row_rd;
			if (cmd.accept) begin
				changed_q <= 1'b0;
			end else if (kind_s2 == SQ_X && hit && !row_q[idx_s2]) begin
				changed_q <= 1'b1;
			end
			if (cmd.clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= sq_a;
		m_s1 <= M_W'(sq_d) * M_W'(sq_p);
		idx_s2 <= idx_s1;
		sq_s2 <= SQ_W'(m_s1) * SQ_W'(m_s1);
		if (kind_s2 == SQ_Z) begin
			dz2_q <= sq_s2;
		end
		if (kind_s2 == SQ_Y) begin
			dyz2_q <= (SQ_W + 1)'(dz2_q) + (SQ_W + 1)'(sq_s2);
		end
		if (rd_pend_q) begin
			row_q <= ram_rdata;
		end else if (kind_s2 == SQ_X && hit) begin
			row_q[idx_s2] <= 1'b1;
		end
	end

	// mask memory, one row of MAX_DIM voxels per (j, k)
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr, ram_raddr;
	logic [MAX_DIM-1:0] ram_wdata;

	assign ram_we = cmd.clr_we | cmd.row_wr;
	assign ram_waddr = cmd.clr_we ? clr_q : {k_q, j_q};
	assign ram_wdata = cmd.clr_we ? '0 : row_q;
	assign ram_raddr = act_q ? {ck_q, cj_q} : {k_q, j_q};

	vsb_ram #(
		.WIDTH (MAX_DIM),
		.DEPTH (ROWS)
	) u_mask (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.row_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register
	logic res_changed_q, res_mask_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_changed_q <= !act_q && changed_q;
			res_mask_q <= act_q && inside_q && row_q[ci_q];
		end
	end

	assign changed = res_changed_q;
	assign mask_bit = res_mask_q;

	assign stat.is_read = act_q;
	assign stat.in_vol = inside_q;
	assign stat.div_done = div_done;
	assign stat.i_last = (i_q == hi_x_q);
	assign stat.j_last = (j_q == hi_y_q);
	assign stat.k_last = (k_q == hi_z_q);
	assign stat.clr_last = &clr_q;

`ifndef SYNTHESIS
	a_wr_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_wr |-> (kind_s1 == SQ_NONE) && (kind_s2 == SQ_NONE))
		else $error("row written back with voxels still in flight");
	a_load_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> kind_s2 != SQ_X)
		else $error("row load collides with voxel update");
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_i |-> (lo_x_q <= hi_x_q) && (lo_y_q <= hi_y_q) && (lo_z_q <= hi_z_q))
		else $error("empty brush span");
`endif

endmodule
`default_nettype wire

>>> design/vsb_ctrl.sv
// Controller: clearing pass, item dispatch, half-width divisions, box walk sequencing and result handshake.
`default_nettype none
module vsb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  vsb_pkg::dp_stat_t  stat,
	output vsb_pkg::dp_cmd_t   cmd
);
	import vsb_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_RD_WAIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SETUP,
		S_PLANE,
		S_ROW,
		S_XRUN,
		S_DRAIN1,
		S_DRAIN2,
		S_WRITE,
		S_DONE
	} state_t;

	state_t state_q;
	axis_t  axis_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.sq = SQ_NONE;
		unique case (state_q)
			S_CLEAR: cmd.clr_we = 1'b1;
			S_IDLE: cmd.accept = in_valid;
			S_RD: cmd.row_rd = 1'b1;
			S_DIV_GO: cmd.div_start = 1'b1;
			S_DIV_WAIT: cmd.span_load = stat.div_done;
			S_SETUP: cmd.init_k = 1'b1;
			S_PLANE: begin
				cmd.sq = SQ_Z;
				cmd.init_j = 1'b1;
			end
			S_ROW: begin
				cmd.sq = SQ_Y;
				cmd.row_rd = 1'b1;
				cmd.init_i = 1'b1;
			end
			S_XRUN: begin
				cmd.sq = SQ_X;
				cmd.inc_i = 1'b1;
			end
			S_WRITE: begin
				cmd.row_wr = 1'b1;
				cmd.inc_j = !stat.j_last;
				cmd.inc_k = stat.j_last && !stat.k_last;
			end
			S_DONE: cmd.out_load = slot_free;
			S_DISPATCH, S_RD_WAIT, S_DRAIN1, S_DRAIN2: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			axis_q <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (!stat.in_vol) begin
						state_q <= S_DONE;
					end else if (stat.is_read) begin
						state_q <= S_RD;
					end else begin
						axis_q <= AXIS_X;
						state_q <= S_DIV_GO;
					end
				end
				S_RD: state_q <= S_RD_WAIT;
				S_RD_WAIT: state_q <= S_DONE;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						unique case (axis_q)
							AXIS_X: begin
								axis_q <= AXIS_Y;
								state_q <= S_DIV_GO;
							end
							AXIS_Y: begin
								axis_q <= AXIS_Z;
								state_q <= S_DIV_GO;
							end
							default: state_q <= S_SETUP;
						endcase
					end
				end
				S_SETUP: state_q <= S_PLANE;
				S_PLANE: state_q <= S_ROW;
				S_ROW: state_q <= S_XRUN;
				S_XRUN: begin
					if (stat.i_last) begin
						state_q <= S_DRAIN1;
					end
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_WRITE;
				S_WRITE: begin
					priority if (!stat.j_last) begin
						state_q <= S_ROW;
					end else if (!stat.k_last) begin
						state_q <= S_PLANE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready && !out_valid_q)
		else $error("item traffic during mask clearing pass");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for voxel_sphere_brush_paint: directed and random paints and reads.
module tb_top;
	import vsb_pkg::*;

	localparam logic ACT_PAINT = 1'b0;
	localparam logic ACT_READ = 1'b1;
	localparam int VOXELS = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int TIMEOUT_CYCLES = 10_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 100;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_PHASE = 1;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 70;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z,
		REG_PITCH_X, REG_PITCH_Y, REG_PITCH_Z, REG_RADIUS};

	typedef struct packed {
		logic changed;
		logic mask_bit;
	} brush_result_t;

	class brush_scoreboard;
		bit voxel_set [VOXELS];
		logic [SIZE_W-1:0] size_reg [3];
		logic [PITCH_W-1:0] pitch_reg [3];
		logic [RAD_W-1:0] radius_reg;
		brush_result_t pending_results [$];
		int unsigned errors;
		int unsigned checked;

		function new();
			size_reg = '{SIZE_RST, SIZE_RST, SIZE_RST};
			pitch_reg = '{PITCH_RST, PITCH_RST, PITCH_RST};
			radius_reg = RADIUS_RST;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SIZE_X: size_reg[0] = data[SIZE_W-1:0];
				REG_SIZE_Y: size_reg[1] = data[SIZE_W-1:0];
				REG_SIZE_Z: size_reg[2] = data[SIZE_W-1:0];
				REG_PITCH_X: pitch_reg[0] = data[PITCH_W-1:0];
				REG_PITCH_Y: pitch_reg[1] = data[PITCH_W-1:0];
				REG_PITCH_Z: pitch_reg[2] = data[PITCH_W-1:0];
				REG_RADIUS: radius_reg = data[RAD_W-1:0];
				default: ;
			endcase
		endfunction

		// Sets every voxel of the clipped box within the radius; returns 1 if any was new.
		function bit paint_sphere(input int unsigned ctr [3], input int unsigned dim [3]);
			longint unsigned span_sq [3][MAX_DIM];
			longint unsigned pitch, half, rad, r2, d;
			int unsigned lo [3];
			int unsigned hi [3];
			int unsigned a, i, j, k, addr;
			bit any_new;
			any_new = 1'b0;
			rad = radius_reg;
			r2 = rad * rad;
			for (a = 0; a < 3; a++) begin
				pitch = (pitch_reg[a] == 0) ? 1 : pitch_reg[a];
				half = (rad + pitch - 1) / pitch;
				lo[a] = 32'((half >= ctr[a]) ? 0 : ctr[a] - half);
				hi[a] = 32'((ctr[a] + half > dim[a] - 1) ? dim[a] - 1 : ctr[a] + half);
				for (i = lo[a]; i <= hi[a]; i++) begin
					d = (i >= ctr[a]) ? i - ctr[a] : ctr[a] - i;
					span_sq[a][i] = (d * pitch) * (d * pitch);
				end
			end
			for (k = lo[2]; k <= hi[2]; k++) begin
				for (j = lo[1]; j <= hi[1]; j++) begin
					for (i = lo[0]; i <= hi[0]; i++) begin
						if (span_sq[0][i] + span_sq[1][j] + span_sq[2][k] <= r2) begin
							addr = i + MAX_DIM * (j + MAX_DIM * k);
							if (!voxel_set[addr]) begin
								voxel_set[addr] = 1'b1;
								any_new = 1'b1;
							end
						end
					end
				end
			end
			return any_new;
		endfunction

		function void take_item(input logic act, input logic [CTR_W-1:0] ci,
				input logic [CTR_W-1:0] cj, input logic [CTR_W-1:0] ck);
			int unsigned ctr [3];
			int unsigned dim [3];
			int unsigned a;
			bit in_vol;
			brush_result_t res;
			ctr = '{ci, cj, ck};
			in_vol = 1'b1;
			res = '0;
			for (a = 0; a < 3; a++) begin
				dim[a] = (size_reg[a] == 0) ? 1 :
					(size_reg[a] > MAX_DIM) ? MAX_DIM : size_reg[a];
				if (ctr[a] >= dim[a])
					in_vol = 1'b0;
			end
			if (act == ACT_READ)
				res.mask_bit = in_vol
					&& voxel_set[ctr[0] + MAX_DIM * (ctr[1] + MAX_DIM * ctr[2])];
			else if (in_vol)
				res.changed = paint_sphere(ctr, dim);
			pending_results.push_back(res);
		endfunction

		function void check_result(input logic got_changed, input logic got_bit);
			brush_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: changed %0b mask_bit %0b", got_changed, got_bit);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (want.changed !== got_changed || want.mask_bit !== got_bit) begin
				errors++;
				if (errors <= 10)
					$display({"result %0d: expected changed %0b mask_bit %0b, ",
						"got changed %0b mask_bit %0b"},
						checked, want.changed, want.mask_bit, got_changed, got_bit);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_PAINT;
	logic [CTR_W-1:0] center_i = '0;
	logic [CTR_W-1:0] center_j = '0;
	logic [CTR_W-1:0] center_k = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic changed;
	logic mask_bit;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	brush_scoreboard sb;
	bit hold_request = 1'b0;
	int unsigned cycle_count = 0;

	voxel_sphere_brush_paint u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(changed, mask_bit);
			if (in_valid && in_ready)
				sb.take_item(action, center_i, center_j, center_k);
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	task automatic offer_item(input logic act, input logic [CTR_W-1:0] ci,
			input logic [CTR_W-1:0] cj, input logic [CTR_W-1:0] ck, input int unsigned gap);
		in_valid <= 1'b1;
		action <= act;
		center_i <= ci;
		center_j <= cj;
		center_k <= ck;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] vals [7]);
		int unsigned n;
		for (n = 0; n < 7; n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[n];
			cfg_data <= vals[n];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned run_len, stall_len;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			run_len = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len != 0) begin
				out_ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] cfg_vals [7];
		int unsigned vol [3];
		int unsigned last_c [3];
		int unsigned phase, n, a, roll, min_pitch, lim, p;
		int near;
		bit small_vol, quiet;
		logic act;
		logic [CTR_W-1:0] pos [3];
		sb = new();
		last_c = '{0, 0, 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: corners clip the box low and high
		offer_item(ACT_READ, 0, 0, 0, 0);
		offer_item(ACT_PAINT, 0, 0, 0, 0);
		offer_item(ACT_PAINT, 0, 0, 0, 0);
		offer_item(ACT_READ, 3, 0, 0, 0);
		offer_item(ACT_READ, 4, 0, 0, 0);
		offer_item(ACT_READ, 2, 2, 1, 0);
		offer_item(ACT_PAINT, 63, 63, 63, 0);
		offer_item(ACT_READ, 63, 63, 63, 0);

		// zero size and pitch, oversized size, zero radius
		drain();
		cfg_vals = '{16'd0, 16'd127, 16'd64, 16'd0, 16'd65535, 16'd256, 16'd0};
		apply_settings(cfg_vals);
		offer_item(ACT_PAINT, 0, 10, 20, 0);
		offer_item(ACT_PAINT, 1, 10, 20, 0);
		offer_item(ACT_READ, 3, 0, 0, 0);
		offer_item(ACT_READ, 0, 10, 20, 0);
		offer_item(ACT_READ, 0, 11, 20, 0);

		// huge radius, box clipped on both sides of a small volume
		drain();
		cfg_vals = '{16'd5, 16'd6, 16'd4, 16'd1, 16'd0, 16'd1, 16'd65535};
		apply_settings(cfg_vals);
		offer_item(ACT_PAINT, 2, 3, 1, 0);
		offer_item(ACT_READ, 4, 5, 3, 0);
		offer_item(ACT_READ, 0, 0, 0, 0);

		// maximum pitch and radius: exact boundary on one-step neighbours
		drain();
		cfg_vals = '{16'd64, 16'd64, 16'd64, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
		apply_settings(cfg_vals);
		offer_item(ACT_PAINT, 30, 30, 30, 0);
		offer_item(ACT_READ, 31, 30, 30, 0);
		offer_item(ACT_READ, 31, 31, 30, 0);
		offer_item(ACT_READ, 30, 30, 29, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase == HOLD_PHASE) begin
				cfg_vals = '{SIZE_RST, SIZE_RST, SIZE_RST, PITCH_RST, PITCH_RST, PITCH_RST,
					RADIUS_RST};
			end else begin
				for (a = 0; a < 3; a++) begin
					roll = $urandom_range(0, 99);
					if (roll < 45)
						cfg_vals[a] = CFG_DATA_W'($urandom_range(1, 64));
					else if (roll < 75)
						cfg_vals[a] = CFG_DATA_W'($urandom_range(1, 12));
					else if (roll < 90)
						cfg_vals[a] = CFG_DATA_W'($urandom_range(65, 127));
					else
						cfg_vals[a] = 0;
					roll = $urandom_range(0, 99);
					if (roll < 50)
						cfg_vals[3 + a] = CFG_DATA_W'($urandom_range(64, 1024));
					else if (roll < 75)
						cfg_vals[3 + a] = CFG_DATA_W'($urandom_range(0, 65535));
					else if (roll < 85)
						cfg_vals[3 + a] = 0;
					else
						cfg_vals[3 + a] = CFG_DATA_W'($urandom_range(1, 63));
				end
			end
			small_vol = 1'b1;
			min_pitch = 65535;
			for (a = 0; a < 3; a++) begin
				vol[a] = (cfg_vals[a] == 0) ? 1 : (cfg_vals[a] > MAX_DIM) ? MAX_DIM : cfg_vals[a];
				if (vol[a] > 12)
					small_vol = 1'b0;
				p = (cfg_vals[3 + a] == 0) ? 1 : cfg_vals[3 + a];
				if (p < min_pitch)
					min_pitch = p;
			end
			// keep the box to a few voxels per side unless the volume itself is small
			if (phase != HOLD_PHASE) begin
				lim = (small_vol || 4 * min_pitch > 65535) ? 65535 : 4 * min_pitch;
				cfg_vals[6] = CFG_DATA_W'($urandom_range(0, lim));
			end
			apply_settings(cfg_vals);
			if (phase == HOLD_PHASE)
				hold_request = 1'b1;
			quiet = (phase == HOLD_PHASE) || (phase == 4);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				act = ($urandom_range(0, 99) < 55) ? ACT_PAINT : ACT_READ;
				roll = $urandom_range(0, 99);
				for (a = 0; a < 3; a++) begin
					if (roll < 10) begin
						pos[a] = CTR_W'($urandom_range(0, 63));
					end else if (act == ACT_READ && roll < 60) begin
						near = int'(last_c[a]) + int'($urandom_range(0, 6)) - 3;
						pos[a] = CTR_W'((near < 0) ? 0 : (near > 63) ? 63 : near);
					end else begin
						pos[a] = CTR_W'($urandom_range(0, vol[a] - 1));
					end
				end
				if (act == ACT_PAINT)
					last_c = '{pos[0], pos[1], pos[2]};
				offer_item(act, pos[0], pos[1], pos[2], quiet ? 0 : pick_gap());
			end
		end

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

>>> filelist.f
design/vsb_pkg.sv
design/vsb_ram.sv
design/vsb_div.sv
design/vsb_dp.sv
design/vsb_ctrl.sv
design/voxel_sphere_brush_paint.sv
test/tb_top.sv
